### hdl/fud_pkg.sv
// shared types, constants and helper functions for the form field url decoder
package fud_pkg;

	localparam int MAX_KEY_CHARS   = 8;
	localparam int MAX_VALUE_BYTES = 64;

	// configuration register indexes
	localparam logic [1:0] REG_KEY_TEXT    = 2'd0;
	localparam logic [1:0] REG_KEY_LENGTH  = 2'd1;
	localparam logic [1:0] REG_VALUE_LIMIT = 2'd2;

	// reset values of the configuration registers
	localparam logic [3:0] KEY_LENGTH_RESET  = 4'd4;
	localparam logic [6:0] VALUE_LIMIT_RESET = 7'd32;

	// result kinds
	localparam logic [1:0] KIND_BYTE    = 2'd0;
	localparam logic [1:0] KIND_FOUND   = 2'd1;
	localparam logic [1:0] KIND_MISSING = 2'd2;

	// characters with a special meaning in the body
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_MINUS   = 8'h2D;
	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_AMP     = 8'h26;
	localparam logic [7:0] CH_EQUALS  = 8'h3D;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_TAB     = 8'h09;
	localparam logic [7:0] CH_LF      = 8'h0A;
	localparam logic [7:0] CH_VT      = 8'h0B;
	localparam logic [7:0] CH_FF      = 8'h0C;
	localparam logic [7:0] CH_CR      = 8'h0D;

	typedef enum logic [1:0] {
		PH_NAME,
		PH_SKIP,
		PH_VALUE,
		PH_DONE
	} phase_t;

	typedef enum logic [1:0] {
		PCT_NONE,
		PCT_SEEN,
		PCT_HELD
	} pct_t;

	typedef struct packed {
		logic [63:0] key_text;
		logic [3:0]  key_length;
		logic [6:0]  value_limit;
	} cfg_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data;
	} result_t;

	// all results of one input beat, slot 0 first
	typedef struct packed {
		logic [1:0]        count;
		result_t [2:0]     res;
	} bundle_t;

	// base-16 digit: valid flag and value
	function automatic logic [4:0] hex_digit(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, 4'(c - 8'h30)};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			r = {1'b1, 4'(c - 8'h57)};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r = {1'b1, 4'(c - 8'h37)};
		end
		return r;
	endfunction

	// two-character escape parsed like strtol in base 16
	function automatic logic [7:0] hex_pair(input logic [7:0] a, input logic [7:0] b);
		logic [4:0] da;
		logic [4:0] db;
		logic       space;
		logic [7:0] r;
		da = hex_digit(a);
		db = hex_digit(b);
		space = (a == CH_SPACE) || (a == CH_TAB) || (a == CH_LF) ||
			(a == CH_VT) || (a == CH_FF) || (a == CH_CR);
		if (space || a == CH_PLUS) begin
			r = db[4] ? {4'd0, db[3:0]} : 8'd0;
		end else if (a == CH_MINUS) begin
			r = db[4] ? (8'd0 - {4'd0, db[3:0]}) : 8'd0;
		end else if (da[4]) begin
			r = db[4] ? {da[3:0], db[3:0]} : {4'd0, da[3:0]};
		end else begin
			r = 8'd0;
		end
		return r;
	endfunction

	// append one result to a bundle
	function automatic bundle_t add_result(input bundle_t bin, input logic [1:0] kind,
			input logic [7:0] data);
		bundle_t bout;
		bout = bin;
		unique case (bin.count)
			2'd0: bout.res[0] = '{kind: kind, data: data};
			2'd1: bout.res[1] = '{kind: kind, data: data};
			default: bout.res[2] = '{kind: kind, data: data};
		endcase
		bout.count = bin.count + 2'd1;
		return bout;
	endfunction

endpackage

### hdl/form_field_url_decoder_unit.sv
// top level of the form field url decoder: configuration registers and the three parts
// output: each result beat passes through the bundle queue and then the output register;
// later results of the same beat follow one a cycle while out_stall is low
// throughput: one input beat per cycle; each bundle keeps its slot of the two-entry
// queue until its last result is loaded, and the input stalls only while both are full
// reset: arst_n clears the parser to field-name matching, empties the queue and output
// register, and loads key_length 4, value_limit 32 and key_text 0
module form_field_url_decoder_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  logic [1:0]  wr_index,
	input  logic [63:0] wr_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  in_byte,
	input  logic        body_end,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  out_kind,
	output logic [7:0]  out_byte,
	output logic        run_last
);
	import fud_pkg::*;

	cfg_t    cfg_q;
	logic    push;
	bundle_t push_data;
	bundle_t head;
	logic    empty;
	logic    full;
	logic    pop;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.key_text    <= 64'd0;
			cfg_q.key_length  <= KEY_LENGTH_RESET;
			cfg_q.value_limit <= VALUE_LIMIT_RESET;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_KEY_TEXT:    cfg_q.key_text    <= wr_data;
				REG_KEY_LENGTH:  cfg_q.key_length  <= wr_data[3:0];
				REG_VALUE_LIMIT: cfg_q.value_limit <= wr_data[6:0];
				default: begin
				end
			endcase
		end
	end

	fud_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (in_valid),
		.in_byte   (in_byte),
		.body_end  (body_end),
		.q_full    (full),
		.in_stall  (in_stall),
		.push      (push),
		.push_data (push_data)
	);

	fud_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.empty     (empty),
		.full      (full)
	);

	fud_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.empty     (empty),
		.pop       (pop),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_kind  (out_kind),
		.out_byte  (out_byte),
		.run_last  (run_last)
	);

endmodule

### hdl/fud_front.sv
// front end: parses each body byte and builds the bundle of results it causes
module fud_front (
	input  logic             clk,
	input  logic             arst_n,
	input  fud_pkg::cfg_t    cfg,
	input  logic             in_valid,
	input  logic [7:0]       in_byte,
	input  logic             body_end,
	input  logic             q_full,
	output logic             in_stall,
	output logic             push,
	output fud_pkg::bundle_t push_data
);
	import fud_pkg::*;

	phase_t     phase_q;
	logic [3:0] pos_q;
	pct_t       pct_q;
	logic [7:0] held_q;
	logic [6:0] cnt_q;

	phase_t     phase_d;
	logic [3:0] pos_d;
	pct_t       pct_d;
	logic [7:0] held_d;
	logic [6:0] cnt_d;
	bundle_t    bnd;
	logic       fin;
	logic [3:0] klen;
	logic [6:0] lim;
	logic [7:0] kc;
	logic       accept;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;
	assign push     = accept && (bnd.count != 2'd0);
	assign push_data = bnd;

	// clamped limits and the key character under test
	assign klen = (cfg.key_length > 4'(MAX_KEY_CHARS)) ? 4'(MAX_KEY_CHARS) : cfg.key_length;
	assign lim  = (cfg.value_limit > 7'(MAX_VALUE_BYTES)) ? 7'(MAX_VALUE_BYTES)
		: cfg.value_limit;
	assign kc   = cfg.key_text[{pos_q[2:0], 3'b000} +: 8];

	// next parser state and results of this beat
	always_comb begin
		phase_d = phase_q;
		pos_d   = pos_q;
		pct_d   = pct_q;
		held_d  = held_q;
		cnt_d   = cnt_q;
		bnd     = '0;
		fin     = 1'b0;
		unique case (phase_q)
			PH_NAME: begin
				if (in_byte == CH_AMP) begin
					pos_d = 4'd0;
				end else if (pos_q < klen) begin
					if (in_byte == kc) pos_d = pos_q + 4'd1;
					else phase_d = PH_SKIP;
				end else if (in_byte == CH_EQUALS) begin
					phase_d = PH_VALUE;
					pct_d   = PCT_NONE;
					held_d  = 8'd0;
					cnt_d   = 7'd0;
				end else begin
					phase_d = PH_SKIP;
				end
			end
			PH_SKIP: begin
				if (in_byte == CH_AMP) begin
					phase_d = PH_NAME;
					pos_d   = 4'd0;
				end
			end
			PH_VALUE: begin
				if (in_byte == CH_AMP) begin
					fin = 1'b1;
				end else begin
					priority if (pct_q == PCT_SEEN) begin
						held_d = in_byte;
						pct_d  = PCT_HELD;
					end else if (pct_q == PCT_HELD) begin
						if (cnt_d < lim) begin
							bnd   = add_result(bnd, KIND_BYTE, hex_pair(held_q, in_byte));
							cnt_d = cnt_d + 7'd1;
						end
						pct_d = PCT_NONE;
					end else if (in_byte == CH_PERCENT) begin
						pct_d = PCT_SEEN;
					end else begin
						if (cnt_d < lim) begin
							bnd   = add_result(bnd, KIND_BYTE,
								(in_byte == CH_PLUS) ? CH_SPACE : in_byte);
							cnt_d = cnt_d + 7'd1;
						end
					end
				end
			end
			default: begin
			end
		endcase
		if (body_end && phase_d == PH_VALUE) fin = 1'b1;
		// end of value: flush a cut-short escape, then report found
		if (fin) begin
			if (pct_d != PCT_NONE) begin
				if (cnt_d < lim) begin
					bnd   = add_result(bnd, KIND_BYTE, CH_PERCENT);
					cnt_d = cnt_d + 7'd1;
				end
				if (pct_d == PCT_HELD && cnt_d < lim) begin
					bnd   = add_result(bnd, KIND_BYTE,
						(held_d == CH_PLUS) ? CH_SPACE : held_d);
					cnt_d = cnt_d + 7'd1;
				end
			end
			pct_d   = PCT_NONE;
			bnd     = add_result(bnd, KIND_FOUND, 8'd0);
			phase_d = PH_DONE;
		end
		// end of body: report a miss unless the key was found, and restart
		if (body_end) begin
			if (!fin && phase_d != PH_DONE) bnd = add_result(bnd, KIND_MISSING, 8'd0);
			phase_d = PH_NAME;
			pos_d   = 4'd0;
			pct_d   = PCT_NONE;
			held_d  = 8'd0;
			cnt_d   = 7'd0;
		end
	end

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_NAME;
			pos_q   <= 4'd0;
			pct_q   <= PCT_NONE;
			held_q  <= 8'd0;
			cnt_q   <= 7'd0;
		end else if (accept) begin
			phase_q <= phase_d;
			pos_q   <= pos_d;
			pct_q   <= pct_d;
			held_q  <= held_d;
			cnt_q   <= cnt_d;
		end
	end

endmodule

### hdl/fud_queue.sv
// two-entry queue of result bundles between front and back end
module fud_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  fud_pkg::bundle_t push_data,
	input  logic             pop,
	output fud_pkg::bundle_t head,
	output logic             empty,
	output logic             full
);
	import fud_pkg::*;

	bundle_t    slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign head  = slot_q[rd_ptr_q];
	assign empty = (count_q == 2'd0);
	assign full  = (count_q == 2'd2);

	// bundle storage
	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= push_data;
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop) rd_ptr_q <= !rd_ptr_q;
			unique case ({push, pop})
				2'b10: count_q <= count_q + 2'd1;
				2'b01: count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push) else $error("bundle queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> !pop) else $error("bundle queue underflow");
	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3) else $error("bundle queue level out of range");

endmodule

### hdl/fud_back.sv
// back end: unpacks bundles into single result beats through an output register
module fud_back (
	input  logic             clk,
	input  logic             arst_n,
	input  fud_pkg::bundle_t head,
	input  logic             empty,
	output logic             pop,
	input  logic             out_stall,
	output logic             out_valid,
	output logic [1:0]       out_kind,
	output logic [7:0]       out_byte,
	output logic             run_last
);
	import fud_pkg::*;

	logic       valid_q;
	logic [1:0] kind_q;
	logic [7:0] byte_q;
	logic       last_q;
	logic [1:0] idx_q;
	logic       load;
	logic       is_last;
	result_t    cur;

	assign out_valid = valid_q;
	assign out_kind  = kind_q;
	assign out_byte  = byte_q;
	assign run_last  = last_q;

	// pick the next result of the head bundle
	assign load    = (!valid_q || !out_stall) && !empty;
	assign is_last = (idx_q == head.count - 2'd1);
	assign pop     = load && is_last;

	always_comb begin
		unique case (idx_q)
			2'd0: cur = head.res[0];
			2'd1: cur = head.res[1];
			default: cur = head.res[2];
		endcase
	end

	// output register and slot counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= 2'd0;
		end else if (!valid_q || !out_stall) begin
			valid_q <= !empty;
			if (load) idx_q <= is_last ? 2'd0 : idx_q + 2'd1;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (load) begin
			kind_q <= cur.kind;
			byte_q <= cur.data;
			last_q <= is_last;
		end
	end

endmodule
